// ===== design/lbc_pkg.sv =====
// shared types and constants for the (16,8) linear block codec
// no dependencies; used by lbc_regs, lbc_core and the top level
`default_nettype none

package lbc_pkg;

  localparam int PARITY_BITS = 8;
  localparam int CODE_BITS   = 16;
  localparam int DATA_BITS   = CODE_BITS - PARITY_BITS;
  localparam int ROW_COUNT   = 8;
  localparam int ROW_WIDTH   = 16;
  localparam int ADDR_WIDTH  = 5;
  localparam int PDATA_WIDTH = 32;

  // byte address of a row is 4*index
  localparam int ADDR_LSB = 2;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef logic [ROW_COUNT-1:0][ROW_WIDTH-1:0] row_array_t;

  localparam row_array_t ROW_RESET = '{
    16'd33008, 16'd16588, 16'd8362, 16'd4182,
    16'd2281,  16'd1173,  16'd635,  16'd487
  };

  typedef struct packed {
    logic [CODE_BITS-1:0]   word;
    logic [DATA_BITS-1:0]   data;
    logic [PARITY_BITS-1:0] syndrome;
    logic                   error_seen;
    logic                   bit_fixed;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lbc_regs.sv =====
// parity-check matrix row registers behind an apb-style port
// depends on lbc_pkg
`default_nettype none

module lbc_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lbc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [lbc_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic      [lbc_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                                 pready,
  output lbc_pkg::row_array_t                  rows
);
  import lbc_pkg::*;

  logic [ADDR_WIDTH-ADDR_LSB-1:0] index;
  logic                           wr_en;

  assign index  = paddr[ADDR_WIDTH-1:ADDR_LSB];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= ROW_RESET;
    end else if (wr_en) begin
      rows[index] <= pwdata[ROW_WIDTH-1:0];
    end
  end

  assign prdata = {{(PDATA_WIDTH-ROW_WIDTH){1'b0}}, rows[index]};

endmodule

`default_nettype wire

// ===== design/lbc_core.sv =====
// encode / syndrome-decode logic for one item, purely combinational
// depends on lbc_pkg
`default_nettype none

module lbc_core (
  input  wire logic                          func,
  input  wire logic [lbc_pkg::CODE_BITS-1:0] word_in,
  input  lbc_pkg::row_array_t                rows,
  output lbc_pkg::result_t                   result
);
  import lbc_pkg::*;

  logic [DATA_BITS-1:0]   data;
  logic [PARITY_BITS-1:0] parity;
  logic [PARITY_BITS-1:0] syn;
  logic [CODE_BITS-1:0]   flip;
  logic [PARITY_BITS-1:0] col [CODE_BITS];

  assign data = word_in[DATA_BITS-1:0];

  always_comb begin
    for (int r = 0; r < PARITY_BITS; r++) begin
      parity[r] = ^(rows[r][DATA_BITS-1:0] & data);
      syn[r]    = ^(rows[r][CODE_BITS-1:0] & word_in);
    end
  end

  // a bit flips when its matrix column equals a nonzero syndrome
  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      for (int r = 0; r < PARITY_BITS; r++) begin
        col[i][r] = rows[r][i];
      end
      flip[i] = (syn != '0) && (col[i] == syn);
    end
  end

  always_comb begin
    unique case (func)
      FUNC_ENCODE: begin
        result.word       = {parity, data};
        result.syndrome   = '0;
        result.error_seen = 1'b0;
        result.bit_fixed  = 1'b0;
      end
      FUNC_DECODE: begin
        result.word       = word_in ^ flip;
        result.syndrome   = syn;
        result.error_seen = (syn != '0);
        result.bit_fixed  = |flip;
      end
      default: begin
        result.word       = word_in;
        result.syndrome   = '0;
        result.error_seen = 1'b0;
        result.bit_fixed  = 1'b0;
      end
    endcase
    result.data = result.word[DATA_BITS-1:0];
  end

endmodule

`default_nettype wire

// ===== design/linear_block_16_8_codec_top.sv =====
// top level of the (16,8) linear block codec: input register, core, result register
// depends on lbc_pkg, lbc_regs, lbc_core
`default_nettype none

// Systematic (16,8) binary linear block encoder / syndrome decoder. func 0 encodes
// the data byte in word_in[7:0] into a codeword with parity bit r at bit 8+r; func 1
// decodes a received word, computes the 8-bit syndrome and flips every bit whose
// parity-check column equals a nonzero syndrome. The eight matrix rows are the
// registers at byte addresses 0x00..0x1C and reset to the ROW_RESET matrix; write them
// only while no item is in flight. An item passes the input register and then the result
// register, where its result is presented; one item is taken every cycle as long as
// out_ready stays high, and the single core between the two registers sets that rate
// of one item per clock.
module linear_block_16_8_codec_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic [lbc_pkg::CODE_BITS-1:0]   word_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [lbc_pkg::CODE_BITS-1:0]   word_out,
  output logic      [lbc_pkg::DATA_BITS-1:0]   data_out,
  output logic      [lbc_pkg::PARITY_BITS-1:0] syndrome,
  output logic                                 error_seen,
  output logic                                 bit_fixed,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lbc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [lbc_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic      [lbc_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                                 pready
);
  import lbc_pkg::*;

  row_array_t           rows;
  logic                 s1_valid;
  logic                 s1_func;
  logic [CODE_BITS-1:0] s1_word;
  result_t              core_result;
  result_t              result;
  logic                 advance;

  lbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows)
  );

  lbc_core u_core (
    .func    (s1_func),
    .word_in (s1_word),
    .rows    (rows),
    .result  (core_result)
  );

  // result register free or being drained this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance || !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_word <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= core_result;
    end
  end

  assign word_out   = result.word;
  assign data_out   = result.data;
  assign syndrome   = result.syndrome;
  assign error_seen = result.error_seen;
  assign bit_fixed  = result.bit_fixed;

endmodule

`default_nettype wire
